[design/kernel_moment_integral_macros.svh]
// Assertion macros for the kernel moment integral block.
`ifndef KERNEL_MOMENT_INTEGRAL_MACROS_SVH
`define KERNEL_MOMENT_INTEGRAL_MACROS_SVH
`ifndef SYNTHESIS
`define KMI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmi check failed");
`define KMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmi check failed");
`else
`define KMI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KMI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/kmi_pkg.sv]
// Constants, codes, reciprocal tables and rounding multiply for the moment integral.
package kmi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_DEGREE  = 15;
  localparam int NPOW        = 15;
  localparam logic signed [17:0] ONE = 18'sd65536;
  localparam logic signed [24:0] LIM = 25'sd131072;

  localparam logic [1:0] KS_UNIFORM    = 2'd0;
  localparam logic [1:0] KS_TRIANGULAR = 2'd1;
  localparam logic [1:0] KS_EPAN       = 2'd2;
  localparam logic [1:0] KS_UNKNOWN    = 2'd3;

  localparam longint unsigned TWO32 = 64'h1_0000_0000;

  localparam logic [31:0] RECIP_UNI [16] = '{
    32'((TWO32 + 1) / 2),     32'((TWO32 + 2) / 4),     32'((TWO32 + 3) / 6),
    32'((TWO32 + 4) / 8),     32'((TWO32 + 5) / 10),    32'((TWO32 + 6) / 12),
    32'((TWO32 + 7) / 14),    32'((TWO32 + 8) / 16),    32'((TWO32 + 9) / 18),
    32'((TWO32 + 10) / 20),   32'((TWO32 + 11) / 22),   32'((TWO32 + 12) / 24),
    32'((TWO32 + 13) / 26),   32'((TWO32 + 14) / 28),   32'((TWO32 + 15) / 30),
    32'((TWO32 + 16) / 32)
  };

  localparam logic [31:0] RECIP_TRI [16] = '{
    32'((TWO32 + 1) / 2),     32'((TWO32 + 3) / 6),     32'((TWO32 + 6) / 12),
    32'((TWO32 + 10) / 20),   32'((TWO32 + 15) / 30),   32'((TWO32 + 21) / 42),
    32'((TWO32 + 28) / 56),   32'((TWO32 + 36) / 72),   32'((TWO32 + 45) / 90),
    32'((TWO32 + 55) / 110),  32'((TWO32 + 66) / 132),  32'((TWO32 + 78) / 156),
    32'((TWO32 + 91) / 182),  32'((TWO32 + 105) / 210), 32'((TWO32 + 120) / 240),
    32'((TWO32 + 136) / 272)
  };

  localparam logic [31:0] RECIP_EPA [16] = '{
    32'((TWO32 + 6) / 12),    32'((TWO32 + 16) / 32),   32'((TWO32 + 30) / 60),
    32'((TWO32 + 48) / 96),   32'((TWO32 + 70) / 140),  32'((TWO32 + 96) / 192),
    32'((TWO32 + 126) / 252), 32'((TWO32 + 160) / 320), 32'((TWO32 + 198) / 396),
    32'((TWO32 + 240) / 480), 32'((TWO32 + 286) / 572), 32'((TWO32 + 336) / 672),
    32'((TWO32 + 390) / 780), 32'((TWO32 + 448) / 896), 32'((TWO32 + 510) / 1020),
    32'((TWO32 + 576) / 1152)
  };

  function automatic logic signed [23:0] rmul(input logic signed [23:0] x,
                                              input logic signed [23:0] y);
    logic        neg;
    logic [23:0] ux;
    logic [23:0] uy;
    logic [47:0] prod;
    logic [23:0] mag;
    neg  = x[23] ^ y[23];
    ux   = x[23] ? 24'(-x) : 24'(x);
    uy   = y[23] ? 24'(-y) : 24'(y);
    prod = ({24'd0, ux} * {24'd0, uy}) + 48'(1 << (FRAC_BITS - 1));
    mag  = 24'(prod >> FRAC_BITS);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

[design/kernel_moment_integral.sv]
// Kernel partial moment integral: fully pipelined top level.
// Integrates u^l times the uniform, triangular or Epanechnikov kernel from
// lower_limit to upper_limit (Q1.16) and returns a saturated Q2.16 value. The
// pipeline is 22 register stages deep: one input stage, fifteen power stages
// (one rounded 18x18 multiply per limit each), an absolute-value and square stage,
// then coefficient, product, numerator, reciprocal-multiply and saturation stages.
// A request can enter every cycle unless the result side stalls; a stall on the
// result side freezes the whole pipeline and also stalls the input. The kernel
// shape (shape_r) is read live; the user must see that it is written only while
// the pipeline is empty, since the block itself does not enforce this.
`include "kernel_moment_integral_macros.svh"
module kernel_moment_integral (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_degree,
  input  logic signed [17:0] in_lower_limit,
  input  logic signed [17:0] in_upper_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] out_integral_value,
  output logic               out_saturated
);

  localparam int NP = kmi_pkg::NPOW;

  logic [1:0] shape_r;

  logic               pv_r [0:NP];
  logic [3:0]         pl_r [0:NP];
  logic signed [17:0] pau_r [0:NP];
  logic signed [17:0] pbu_r [0:NP];
  logic signed [17:0] ppa_r [0:NP];
  logic signed [17:0] ppb_r [0:NP];

  logic               v16_r, v17_r, v18_r, v19_r, v20_r, out_valid_r;
  logic [3:0]         l16_r, l17_r, l18_r;
  logic signed [17:0] pa16_r, pb16_r, pa17_r, pb17_r, pa18_r, pb18_r;
  logic [17:0]        absa16_r, absb16_r, aa16_r, bb16_r;
  logic [22:0]        ca17_r, cb17_r;
  logic signed [23:0] ta18_r, tb18_r;
  logic signed [24:0] num19_r;
  logic [31:0]        rcp19_r;
  logic signed [24:0] v20_val_r;
  logic signed [18:0] out_val_r;
  logic               out_sat_r;

  logic               advance;
  logic [3:0]         l_in;
  logic signed [17:0] a_in, b_in;
  logic [22:0]        ca_nxt, cb_nxt;
  logic signed [24:0] num_nxt;
  logic [31:0]        rcp_nxt;
  logic [23:0]        nmag;
  logic [55:0]        vprod;
  logic [23:0]        vmag;
  logic signed [24:0] v_nxt;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  always_comb begin
    l_in = (in_degree > 4'(kmi_pkg::MAX_DEGREE)) ? 4'(kmi_pkg::MAX_DEGREE) : in_degree;
    a_in = in_lower_limit;
    if (in_lower_limit > kmi_pkg::ONE) a_in = kmi_pkg::ONE;
    if (in_lower_limit < -kmi_pkg::ONE) a_in = -kmi_pkg::ONE;
    b_in = in_upper_limit;
    if (in_upper_limit > kmi_pkg::ONE) b_in = kmi_pkg::ONE;
    if (in_upper_limit < -kmi_pkg::ONE) b_in = -kmi_pkg::ONE;
  end

  always_comb begin
    if (shape_r == kmi_pkg::KS_TRIANGULAR) begin
      ca_nxt = 23'((({19'd0, l16_r} + 23'd2) << kmi_pkg::FRAC_BITS)
               - 23'(absa16_r * ({1'b0, l16_r} + 5'd1)));
      cb_nxt = 23'((({19'd0, l16_r} + 23'd2) << kmi_pkg::FRAC_BITS)
               - 23'(absb16_r * ({1'b0, l16_r} + 5'd1)));
    end else begin
      ca_nxt = 23'((({19'd0, l16_r} + 23'd3) << kmi_pkg::FRAC_BITS)
               - 23'(aa16_r * ({1'b0, l16_r} + 5'd1)));
      cb_nxt = 23'((({19'd0, l16_r} + 23'd3) << kmi_pkg::FRAC_BITS)
               - 23'(bb16_r * ({1'b0, l16_r} + 5'd1)));
    end
  end

  always_comb begin
    unique case (shape_r)
      kmi_pkg::KS_UNIFORM: begin
        num_nxt = 25'(pb18_r) - 25'(pa18_r);
        rcp_nxt = kmi_pkg::RECIP_UNI[l18_r];
      end
      kmi_pkg::KS_TRIANGULAR: begin
        num_nxt = 25'(tb18_r) - 25'(ta18_r);
        rcp_nxt = kmi_pkg::RECIP_TRI[l18_r];
      end
      kmi_pkg::KS_EPAN: begin
        num_nxt = 25'sd3 * (25'(tb18_r) - 25'(ta18_r));
        rcp_nxt = kmi_pkg::RECIP_EPA[l18_r];
      end
      default: begin
        num_nxt = '0;
        rcp_nxt = '0;
      end
    endcase
  end

  always_comb begin
    nmag  = num19_r[24] ? 24'(-num19_r) : 24'(num19_r);
    vprod = ({32'd0, nmag} * {24'd0, rcp19_r}) + 56'(64'd1 << 31);
    vmag  = 24'(vprod >> 32);
    v_nxt = num19_r[24] ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= kmi_pkg::KS_UNIFORM;
    end else if (cfg_wr_en) begin
      shape_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NP; k++) pv_r[k] <= 1'b0;
      v16_r       <= 1'b0;
      v17_r       <= 1'b0;
      v18_r       <= 1'b0;
      v19_r       <= 1'b0;
      v20_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      pv_r[0]  <= in_valid;
      pl_r[0]  <= l_in;
      pau_r[0] <= a_in;
      pbu_r[0] <= b_in;
      ppa_r[0] <= a_in;
      ppb_r[0] <= b_in;
      for (int k = 1; k <= NP; k++) begin
        pv_r[k]  <= pv_r[k-1];
        pl_r[k]  <= pl_r[k-1];
        pau_r[k] <= pau_r[k-1];
        pbu_r[k] <= pbu_r[k-1];
        if (5'(k) <= {1'b0, pl_r[k-1]}) begin
          ppa_r[k] <= 18'(kmi_pkg::rmul(24'(ppa_r[k-1]), 24'(pau_r[k-1])));
          ppb_r[k] <= 18'(kmi_pkg::rmul(24'(ppb_r[k-1]), 24'(pbu_r[k-1])));
        end else begin
          ppa_r[k] <= ppa_r[k-1];
          ppb_r[k] <= ppb_r[k-1];
        end
      end

      v16_r    <= pv_r[NP];
      l16_r    <= pl_r[NP];
      pa16_r   <= ppa_r[NP];
      pb16_r   <= ppb_r[NP];
      absa16_r <= pau_r[NP][17] ? 18'(-pau_r[NP]) : 18'(pau_r[NP]);
      absb16_r <= pbu_r[NP][17] ? 18'(-pbu_r[NP]) : 18'(pbu_r[NP]);
      aa16_r   <= 18'(kmi_pkg::rmul(24'(pau_r[NP]), 24'(pau_r[NP])));
      bb16_r   <= 18'(kmi_pkg::rmul(24'(pbu_r[NP]), 24'(pbu_r[NP])));

      v17_r  <= v16_r;
      l17_r  <= l16_r;
      pa17_r <= pa16_r;
      pb17_r <= pb16_r;
      ca17_r <= ca_nxt;
      cb17_r <= cb_nxt;

      v18_r  <= v17_r;
      l18_r  <= l17_r;
      pa18_r <= pa17_r;
      pb18_r <= pb17_r;
      ta18_r <= kmi_pkg::rmul(24'(pa17_r), $signed({1'b0, ca17_r}));
      tb18_r <= kmi_pkg::rmul(24'(pb17_r), $signed({1'b0, cb17_r}));

      v19_r   <= v18_r;
      num19_r <= num_nxt;
      rcp19_r <= rcp_nxt;

      v20_r     <= v19_r;
      v20_val_r <= v_nxt;

      out_valid_r <= v20_r;
      if (v20_val_r > kmi_pkg::LIM) begin
        out_val_r <= 19'(kmi_pkg::LIM);
        out_sat_r <= 1'b1;
      end else if (v20_val_r < -kmi_pkg::LIM) begin
        out_val_r <= 19'(-kmi_pkg::LIM);
        out_sat_r <= 1'b1;
      end else begin
        out_val_r <= 19'(v20_val_r);
        out_sat_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_integral_value = out_val_r;
  assign out_saturated      = out_sat_r;

  `KMI_ASSERT_IMPL(a_sat_at_limit, clk, rst_n, out_valid_r && out_sat_r,
    out_val_r == 19'(kmi_pkg::LIM) || out_val_r == 19'(-kmi_pkg::LIM))
  `KMI_ASSERT_IMPL(a_unknown_shape_zero, clk, rst_n,
    out_valid_r && shape_r == kmi_pkg::KS_UNKNOWN, out_val_r == '0 && !out_sat_r)
  `KMI_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, pv_r[0])

endmodule

[sim/kernel_moment_integral_tb.sv]
// Testbench for kernel_moment_integral: random and directed requests checked by a scoreboard.
module kernel_moment_integral_tb;

  typedef struct packed {
    logic signed [18:0] value;
    logic               sat;
  } integral_t;

  class integral_scoreboard;
    integral_t expected_q[$];
    int        errors;

    function longint rnd_mul(longint x, longint y, int s);
      logic              neg;
      logic [63:0]       ux;
      logic [63:0]       uy;
      logic [127:0]      prod;
      longint            r;
      neg  = (x < 0) != (y < 0);
      ux   = x < 0 ? -x : x;
      uy   = y < 0 ? -y : y;
      prod = {64'd0, ux} * {64'd0, uy} + (128'd1 << (s - 1));
      r    = longint'(prod >> s);
      return neg ? -r : r;
    endfunction

    function longint power_of(longint u, int e);
      longint p;
      p = u;
      for (int k = 1; k < e; k++) p = rnd_mul(p, u, kmi_pkg::FRAC_BITS);
      return p;
    endfunction

    function longint clamp_limit(logic signed [17:0] raw);
      longint v;
      v = raw;
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      return v;
    endfunction

    function void note_request(logic [1:0] shape, logic [3:0] deg,
                               logic signed [17:0] lo, logic signed [17:0] hi);
      longint    one, a, b, pa, pb, num, den, recip, v, ca, cb, l;
      integral_t e;
      one = 65536;
      l   = deg;
      a   = clamp_limit(lo);
      b   = clamp_limit(hi);
      v   = 0;
      if (shape != kmi_pkg::KS_UNKNOWN) begin
        pa = power_of(a, l + 1);
        pb = power_of(b, l + 1);
        if (shape == kmi_pkg::KS_UNIFORM) begin
          num = pb - pa;
          den = 2 * (l + 1);
        end else if (shape == kmi_pkg::KS_TRIANGULAR) begin
          ca  = (l + 2) * one - (a < 0 ? -a : a) * (l + 1);
          cb  = (l + 2) * one - (b < 0 ? -b : b) * (l + 1);
          num = rnd_mul(pb, cb, kmi_pkg::FRAC_BITS) - rnd_mul(pa, ca, kmi_pkg::FRAC_BITS);
          den = (l + 1) * (l + 2);
        end else begin
          ca  = (l + 3) * one - rnd_mul(a, a, kmi_pkg::FRAC_BITS) * (l + 1);
          cb  = (l + 3) * one - rnd_mul(b, b, kmi_pkg::FRAC_BITS) * (l + 1);
          num = 3 * (rnd_mul(pb, cb, kmi_pkg::FRAC_BITS)
                     - rnd_mul(pa, ca, kmi_pkg::FRAC_BITS));
          den = 4 * (l + 1) * (l + 3);
        end
        recip = ((64'd1 << 32) + den / 2) / den;
        v     = rnd_mul(num, recip, 32);
      end
      e.sat = 1'b0;
      if (v > 131072) begin
        v = 131072;
        e.sat = 1'b1;
      end else if (v < -131072) begin
        v = -131072;
        e.sat = 1'b1;
      end
      e.value = v[18:0];
      expected_q = {expected_q, e};
    endfunction

    function void check_result(logic signed [18:0] value, logic sat);
      integral_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value %0d sat %0b", $time, value, sat);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (value !== e.value) begin
        $display("%0t: integral_value expected %0d actual %0d", $time, e.value, value);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [1:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_degree;
  logic signed [17:0] in_lower_limit;
  logic signed [17:0] in_upper_limit;
  logic               out_valid;
  logic               out_stall;
  logic signed [18:0] out_integral_value;
  logic               out_saturated;

  integral_scoreboard sb;
  logic [1:0]         shape_now;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  logic               long_hold;
  int                 cycles;

  kernel_moment_integral dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_degree(in_degree),
    .in_lower_limit(in_lower_limit), .in_upper_limit(in_upper_limit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_integral_value(out_integral_value), .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("kernel_moment_integral_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_integral_value, out_saturated);
    out_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_request(logic [3:0] deg, logic signed [17:0] lo, logic signed [17:0] hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_degree      <= deg;
    in_lower_limit <= lo;
    in_upper_limit <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(shape_now, deg, lo, hi);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_shape(logic [1:0] shape);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= shape;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shape_now   = shape;
  endtask

  function automatic logic signed [17:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 18'($urandom);
    if (r == 1) begin
      case ($urandom_range(0, 4))
        0: return -18'sd65536;
        1: return 18'sd65536;
        2: return 18'sd0;
        3: return 18'sh1ffff;
        default: return 18'sh20000;
      endcase
    end
    return 18'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  task automatic directed_set();
    send_request(4'd0, -18'sd65536, 18'sd65536);
    send_request(4'd15, -18'sd65536, 18'sd65536);
    send_request(4'd3, -18'sd40000, 18'sd0);
    send_request(4'd2, 18'sd50000, -18'sd30000);
    send_request(4'd1, 18'sh1ffff, 18'sh20000);
    send_request(4'd15, 18'sd65536, 18'sd65536);
  endtask

  initial begin
    logic [1:0] shapes[7] = '{kmi_pkg::KS_UNIFORM, kmi_pkg::KS_TRIANGULAR, kmi_pkg::KS_EPAN,
                              kmi_pkg::KS_UNKNOWN, kmi_pkg::KS_EPAN, kmi_pkg::KS_TRIANGULAR,
                              kmi_pkg::KS_UNIFORM};
    sb             = new();
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 2'd0;
    in_valid       = 1'b0;
    in_degree      = 4'd0;
    in_lower_limit = 18'sd0;
    in_upper_limit = 18'sd0;
    out_stall      = 1'b0;
    long_hold      = 1'b0;
    shape_now      = kmi_pkg::KS_UNIFORM;
    send_idle_pct  = 22;
    recv_idle_pct  = 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 81;
        recv_idle_pct = 22;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_shape(shapes[ph]);
      if (ph < 4) directed_set();
      fork
        begin
          if (ph == 5) begin
            repeat (40) @(posedge clk);
            long_hold <= 1'b1;
            repeat (200) @(posedge clk);
            long_hold <= 1'b0;
          end
        end
        begin
          for (int i = 0; i < 218; i++)
            send_request(4'($urandom_range(0, 15)), pick_limit(), pick_limit());
        end
      join
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("kernel_moment_integral_tb OK");
    end else begin
      $display("kernel_moment_integral_tb NOT OK");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/kmi_pkg.sv
design/kernel_moment_integral.sv
sim/kernel_moment_integral_tb.sv
